@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Types, codes and widths of the banker's safe allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned RTYPES = 3;
  localparam int unsigned UNIT_W = 8;
  localparam int unsigned CUST_W = 3;
  localparam int unsigned CFG_W  = 2;

  typedef logic [UNIT_W-1:0] unit_t;
  typedef unit_t [RTYPES-1:0] lanes_t;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_CLAIM   = 2'd1,
    OP_REQUEST = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_OVER_NEED = 3'd1,
    ST_WAIT      = 3'd2,
    ST_UNSAFE    = 3'd3,
    ST_ACCEPTED  = 3'd4,
    ST_CLAIM_REJ = 3'd5
  } status_e;

  localparam logic [CFG_W-1:0] CFG_TOTAL_0 = 2'd0;
  localparam logic [CFG_W-1:0] CFG_TOTAL_1 = 2'd1;
  localparam logic [CFG_W-1:0] CFG_TOTAL_2 = 2'd2;

  typedef struct packed {
    opcode_e             opcode;
    logic [CUST_W-1:0]   customer;
    unit_t               amount_0;
    unit_t               amount_1;
    unit_t               amount_2;
  } req_t;

  typedef struct packed {
    status_e status;
    logic    need_met;
    unit_t   left_0;
    unit_t   left_1;
    unit_t   left_2;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] addr;
    unit_t            wdata;
  } cfg_t;

  // write command into the customer table
  typedef struct packed {
    logic   clr;
    logic   max_we;
    logic   held_we;
    lanes_t max_wd;
    lanes_t held_wd;
  } store_wr_t;

endpackage

@@ rtl/bsa_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa interfaces
// Valid/ready channels for operations, results and register writes.
// ----------------------------------------------------------------------------
interface bsa_req_if;
  logic          valid;
  logic          ready;
  bsa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsa_rsp_if;
  logic          valid;
  logic          ready;
  bsa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsa_cfg_if;
  logic          valid;
  logic          ready;
  bsa_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bsa_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_store
// Per-customer table of maximum claim and held units, one read port.
// ----------------------------------------------------------------------------
module bsa_store #(
  parameter int unsigned CUSTOMERS = 8,
  localparam int unsigned AW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsa_pkg::store_wr_t  wr_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [AW-1:0]       raddr_i,
  output bsa_pkg::lanes_t     max_o,
  output bsa_pkg::lanes_t     held_o
);

  bsa_pkg::lanes_t max_q  [CUSTOMERS];
  bsa_pkg::lanes_t held_q [CUSTOMERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CUSTOMERS; i++) begin
        max_q[i]  <= '0;
        held_q[i] <= '0;
      end
    end else if (wr_i.clr) begin
      for (int i = 0; i < CUSTOMERS; i++) begin
        max_q[i]  <= '0;
        held_q[i] <= '0;
      end
    end else begin
      if (wr_i.max_we) begin
        max_q[waddr_i] <= wr_i.max_wd;
      end
      if (wr_i.held_we) begin
        held_q[waddr_i] <= wr_i.held_wd;
      end
    end
  end

  assign max_o  = max_q[raddr_i];
  assign held_o = held_q[raddr_i];

endmodule

@@ rtl/bsa_lane_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_lane_alu
// Three-lane compare and add unit shared by the safety scan, the request check and release.
// ----------------------------------------------------------------------------
module bsa_lane_alu #(
  parameter int unsigned WORK_W = 12
) (
  input  logic [bsa_pkg::RTYPES-1:0][WORK_W-1:0] a_i,
  input  bsa_pkg::lanes_t                        cmp_i,
  input  bsa_pkg::lanes_t                        add_i,
  output logic [bsa_pkg::RTYPES-1:0][WORK_W-1:0] sum_o,
  output logic                                   fits_o
);

  localparam int unsigned EXT_W = WORK_W - bsa_pkg::UNIT_W;

  logic [bsa_pkg::RTYPES-1:0] lane_fits;

  always_comb begin
    for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
      lane_fits[r] = ({EXT_W'(0), cmp_i[r]} <= a_i[r]);
      sum_o[r]     = a_i[r] + {EXT_W'(0), add_i[r]};
    end
  end

  assign fits_o = &lane_fits;

endmodule

@@ rtl/bankers_safe_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safe_allocator
// Banker's deadlock-avoidance allocator, three resource types.
// ----------------------------------------------------------------------------
//  port    | dir | payload              | note
//  req_i   | in  | opcode, customer,    | one operation per request
//          |     | amount_0..2          |
//  rsp_o   | out | status, need_met,    | one result per request
//          |     | left_0..2            |
//  cfg_i   | in  | addr, wdata          | totals, always ready
//
// restart, claim, release and refused requests go from accept through the exec
// and fin states to the result; one that reaches the safety check also runs
// the scan, P passes (1..CUSTOMERS), stepping one customer per cycle through the
// shared lane unit. reset clears control state, totals, available units and
// the table at once. a result that is not taken holds the block in its final
// state; the next request is taken as soon as the result register is loaded.
// ----------------------------------------------------------------------------
module bankers_safe_allocator #(
  parameter int unsigned CUSTOMERS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bsa_req_if.sink          req_i,
  bsa_rsp_if.source        rsp_o,
  bsa_cfg_if.sink          cfg_i
);

  localparam int unsigned AW     = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int unsigned WORK_W = bsa_pkg::UNIT_W + $clog2(CUSTOMERS + 1);
  localparam int unsigned EXT_W  = WORK_W - bsa_pkg::UNIT_W;
  localparam int unsigned CW     = AW + bsa_pkg::CUST_W;
  localparam logic [AW-1:0] LAST = AW'(CUSTOMERS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef logic [bsa_pkg::RTYPES-1:0][WORK_W-1:0] work_t;

  state_e             state_q, state_d;
  bsa_pkg::req_t      req_q, req_d;
  bsa_pkg::lanes_t    total_q, total_d;
  bsa_pkg::lanes_t    avail_q, avail_d;
  bsa_pkg::lanes_t    old_avail_q, old_avail_d;
  bsa_pkg::lanes_t    old_held_q, old_held_d;
  work_t              work_q, work_d;
  logic [CUSTOMERS-1:0] done_q, done_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               prog_q, prog_d;
  bsa_pkg::status_e   status_q, status_d;
  logic               met_q, met_d;
  logic               undo_q, undo_d;
  logic               rsp_valid_q, rsp_valid_d;
  bsa_pkg::rsp_t      rsp_q, rsp_d;

  bsa_pkg::store_wr_t store_wr;
  logic [AW-1:0]      store_raddr;
  bsa_pkg::lanes_t    max_r, held_r, need_r, amt;

  work_t              alu_a, alu_sum;
  bsa_pkg::lanes_t    alu_cmp;
  logic               alu_fits;

  logic [CW-1:0]      cust_wide;
  logic               cust_ok;
  logic [AW-1:0]      cust_addr;
  logic               over, claim_ok, need_zero;
  logic [CUSTOMERS-1:0] done_nx;
  logic               hit, prog_nx;
  logic               req_acc, rsp_load;

  // customer index, clamped to entry zero when out of range
  assign cust_wide = {AW'(0), req_q.customer};
  assign cust_ok   = cust_wide < CW'(CUSTOMERS);
  assign cust_addr = cust_ok ? cust_wide[AW-1:0] : '0;

  assign amt[0] = req_q.amount_0;
  assign amt[1] = req_q.amount_1;
  assign amt[2] = req_q.amount_2;

  assign store_raddr = (state_q == S_SCAN) ? idx_q : cust_addr;

  bsa_store #(
    .CUSTOMERS (CUSTOMERS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (store_wr),
    .waddr_i (cust_addr),
    .raddr_i (store_raddr),
    .max_o   (max_r),
    .held_o  (held_r)
  );

  always_comb begin
    for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
      need_r[r] = max_r[r] - held_r[r];
    end
  end

  // scan compares need against work; otherwise amount against available
  always_comb begin
    if (state_q == S_SCAN) begin
      alu_a   = work_q;
      alu_cmp = need_r;
    end else begin
      for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
        alu_a[r] = {EXT_W'(0), avail_q[r]};
      end
      alu_cmp = amt;
    end
  end

  bsa_lane_alu #(
    .WORK_W (WORK_W)
  ) u_alu (
    .a_i    (alu_a),
    .cmp_i  (alu_cmp),
    .add_i  (held_r),
    .sum_o  (alu_sum),
    .fits_o (alu_fits)
  );

  always_comb begin
    over      = !cust_ok;
    claim_ok  = cust_ok;
    need_zero = 1'b1;
    for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
      if (amt[r] > need_r[r]) over = 1'b1;
      if (amt[r] > total_q[r] || amt[r] < held_r[r]) claim_ok = 1'b0;
      if (amt[r] != need_r[r]) need_zero = 1'b0;
    end
  end

  // one scan step
  always_comb begin
    hit     = !done_q[idx_q] && alu_fits;
    done_nx = done_q;
    if (hit) begin
      done_nx[idx_q] = 1'b1;
    end
    prog_nx = prog_q | hit;
  end

  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    avail_d     = avail_q;
    old_avail_d = old_avail_q;
    old_held_d  = old_held_q;
    work_d      = work_q;
    done_d      = done_q;
    idx_d       = idx_q;
    prog_d      = prog_q;
    status_d    = status_q;
    met_d       = met_q;
    undo_d      = undo_q;
    store_wr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          req_d   = req_i.data;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        met_d    = 1'b0;
        undo_d   = 1'b0;
        status_d = bsa_pkg::ST_ACCEPTED;
        state_d  = S_FIN;
        unique case (req_q.opcode)
          bsa_pkg::OP_RESTART: begin
            avail_d      = total_q;
            store_wr.clr = 1'b1;
          end
          bsa_pkg::OP_CLAIM: begin
            if (claim_ok) begin
              store_wr.max_we = 1'b1;
              store_wr.max_wd = amt;
            end else begin
              status_d = bsa_pkg::ST_CLAIM_REJ;
            end
          end
          bsa_pkg::OP_REQUEST: begin
            if (over) begin
              status_d = bsa_pkg::ST_OVER_NEED;
            end else if (!alu_fits) begin
              status_d = bsa_pkg::ST_WAIT;
            end else begin
              // tentative grant, undone at the end if unsafe
              store_wr.held_we = 1'b1;
              for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
                store_wr.held_wd[r] = held_r[r] + amt[r];
                avail_d[r]          = avail_q[r] - amt[r];
                work_d[r]           = {EXT_W'(0), avail_q[r] - amt[r]};
              end
              old_avail_d = avail_q;
              old_held_d  = held_r;
              met_d       = need_zero;
              done_d      = '0;
              idx_d       = '0;
              prog_d      = 1'b0;
              state_d     = S_SCAN;
            end
          end
          bsa_pkg::OP_RELEASE: begin
            if (cust_ok) begin
              store_wr.held_we = 1'b1;
              store_wr.held_wd = '0;
              for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
                avail_d[r] = (alu_sum[r] > WORK_W'(255)) ? 8'hFF
                                                          : alu_sum[r][7:0];
              end
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        done_d = done_nx;
        if (hit) begin
          work_d = alu_sum;
        end
        if (idx_q == LAST) begin
          idx_d  = '0;
          prog_d = 1'b0;
          if (!prog_nx || (&done_nx)) begin
            state_d = S_FIN;
            if (&done_nx) begin
              status_d = bsa_pkg::ST_GRANTED;
            end else begin
              status_d = bsa_pkg::ST_UNSAFE;
              met_d    = 1'b0;
              undo_d   = 1'b1;
            end
          end
        end else begin
          idx_d  = idx_q + AW'(1);
          prog_d = prog_nx;
        end
      end
      S_FIN: begin
        if (undo_q) begin
          store_wr.held_we = 1'b1;
          store_wr.held_wd = old_held_q;
          avail_d          = old_avail_q;
        end
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_d     = 1'b1;
      rsp_d.status    = status_q;
      rsp_d.need_met  = met_q;
      rsp_d.left_0    = undo_q ? old_avail_q[0] : avail_q[0];
      rsp_d.left_1    = undo_q ? old_avail_q[1] : avail_q[1];
      rsp_d.left_2    = undo_q ? old_avail_q[2] : avail_q[2];
    end
  end

  // register writes
  always_comb begin
    total_d = total_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.addr)
        bsa_pkg::CFG_TOTAL_0: total_d[0] = cfg_i.data.wdata;
        bsa_pkg::CFG_TOTAL_1: total_d[1] = cfg_i.data.wdata;
        bsa_pkg::CFG_TOTAL_2: total_d[2] = cfg_i.data.wdata;
        default: total_d = total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      avail_q     <= '0;
      done_q      <= '0;
      idx_q       <= '0;
      prog_q      <= 1'b0;
      undo_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      avail_q     <= avail_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      prog_q      <= prog_d;
      undo_q      <= undo_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    old_avail_q <= old_avail_d;
    old_held_q  <= old_held_d;
    work_q      <= work_d;
    status_q    <= status_d;
    met_q       <= met_d;
    rsp_q       <= rsp_d;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign cfg_i.ready = 1'b1;

endmodule

@@ rtl/bsa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  bsa_pkg::rsp_t rsp_data_i
);

  `BSA_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped while stalled")
  `BSA_ASSERT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i), "result changed while stalled")
  `BSA_ASSERT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while busy")
  `BSA_ASSERT(a_rsp_not_early, clk_i, rst_ni, $rose(rsp_valid_i) |-> !$past(req_valid_i && req_ready_i), "result right after request")
  `BSA_ASSERT_ALWAYS(a_met_granted, clk_i, rsp_valid_i && rsp_data_i.status != bsa_pkg::ST_GRANTED |-> !rsp_data_i.need_met, "need met on a refused request")

endmodule

bind bankers_safe_allocator bsa_checker u_bsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

@@ tb/sv/bankers_safe_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safe_allocator_checker
// Watches the operation, result and register channels of the allocator, keeps
// its own copy of the bank state and compares every result in arrival order.
// ----------------------------------------------------------------------------
module bankers_safe_allocator_checker #(
  parameter int unsigned CUSTOMERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsa_req_if          req_i,
  bsa_rsp_if          rsp_i,
  bsa_cfg_if          cfg_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  bsa_pkg::unit_t total_units [bsa_pkg::RTYPES];
  bsa_pkg::unit_t free_units  [bsa_pkg::RTYPES];
  bsa_pkg::unit_t claim_max   [CUSTOMERS][bsa_pkg::RTYPES];
  bsa_pkg::unit_t held        [CUSTOMERS][bsa_pkg::RTYPES];
  bsa_pkg::unit_t need        [CUSTOMERS][bsa_pkg::RTYPES];
  bsa_pkg::rsp_t  pending_answers [$];
  bsa_pkg::rsp_t  oldest;
  int unsigned    mismatch_total;

  // classic banker's scan: grow the work vector until nobody else can finish
  function automatic bit all_can_finish();
    int unsigned work [bsa_pkg::RTYPES];
    bit          done [CUSTOMERS];
    int unsigned finished;
    bit          progress;
    bit          fits;
    finished = 0;
    progress = 1'b1;
    for (int r = 0; r < bsa_pkg::RTYPES; r++) work[r] = 32'(free_units[r]);
    for (int c = 0; c < CUSTOMERS; c++) done[c] = 1'b0;
    for (int p = 0; p < CUSTOMERS && progress; p++) begin
      progress = 1'b0;
      for (int c = 0; c < CUSTOMERS; c++) begin
        if (!done[c]) begin
          fits = 1'b1;
          for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
            if (32'(need[c][r]) > work[r]) fits = 1'b0;
          end
          if (fits) begin
            for (int r = 0; r < bsa_pkg::RTYPES; r++) work[r] += 32'(held[c][r]);
            done[c]  = 1'b1;
            finished++;
            progress = 1'b1;
          end
        end
      end
    end
    return finished == CUSTOMERS;
  endfunction

  function automatic bsa_pkg::rsp_t predict_allocation(input bsa_pkg::req_t op);
    bsa_pkg::rsp_t  res;
    bsa_pkg::unit_t amt [bsa_pkg::RTYPES];
    int unsigned    c;
    int unsigned    sum;
    bit             known;
    bit             ok;
    bit             over;
    bit             short_of;
    amt[0]       = op.amount_0;
    amt[1]       = op.amount_1;
    amt[2]       = op.amount_2;
    known        = 32'(op.customer) < CUSTOMERS;
    c            = known ? 32'(op.customer) : 32'd0;
    res.status   = bsa_pkg::ST_ACCEPTED;
    res.need_met = 1'b0;
    case (op.opcode)
      bsa_pkg::OP_RESTART: begin
        for (int r = 0; r < bsa_pkg::RTYPES; r++) free_units[r] = total_units[r];
        for (int k = 0; k < CUSTOMERS; k++) begin
          for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
            claim_max[k][r] = '0;
            held[k][r]      = '0;
            need[k][r]      = '0;
          end
        end
      end
      bsa_pkg::OP_CLAIM: begin
        ok = known;
        for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
          if (amt[r] > total_units[r] || amt[r] < held[c][r]) ok = 1'b0;
        end
        if (ok) begin
          for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
            claim_max[c][r] = amt[r];
            need[c][r]      = amt[r] - held[c][r];
          end
        end else begin
          res.status = bsa_pkg::ST_CLAIM_REJ;
        end
      end
      bsa_pkg::OP_REQUEST: begin
        over     = !known;
        short_of = 1'b0;
        for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
          if (amt[r] > need[c][r]) over = 1'b1;
          if (amt[r] > free_units[r]) short_of = 1'b1;
        end
        if (over) begin
          res.status = bsa_pkg::ST_OVER_NEED;
        end else if (short_of) begin
          res.status = bsa_pkg::ST_WAIT;
        end else begin
          for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
            free_units[r] = free_units[r] - amt[r];
            held[c][r]    = held[c][r] + amt[r];
            need[c][r]    = need[c][r] - amt[r];
          end
          if (all_can_finish()) begin
            res.status   = bsa_pkg::ST_GRANTED;
            res.need_met = need[c][0] == '0 && need[c][1] == '0 && need[c][2] == '0;
          end else begin
            // tentative grant undone
            res.status = bsa_pkg::ST_UNSAFE;
            for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
              free_units[r] = free_units[r] + amt[r];
              held[c][r]    = held[c][r] - amt[r];
              need[c][r]    = need[c][r] + amt[r];
            end
          end
        end
      end
      bsa_pkg::OP_RELEASE: begin
        if (known) begin
          for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
            sum           = 32'(free_units[r]) + 32'(held[c][r]);
            free_units[r] = (sum > 255) ? 8'd255 : bsa_pkg::unit_t'(sum);
            held[c][r]    = '0;
            need[c][r]    = claim_max[c][r];
          end
        end
      end
    endcase
    res.left_0 = free_units[0];
    res.left_1 = free_units[1];
    res.left_2 = free_units[2];
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
        total_units[r] = '0;
        free_units[r]  = '0;
      end
      for (int k = 0; k < CUSTOMERS; k++) begin
        for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
          claim_max[k][r] = '0;
          held[k][r]      = '0;
          need[k][r]      = '0;
        end
      end
      pending_answers.delete();
      mismatch_total = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_answers.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_total++;
        end else begin
          oldest = pending_answers.pop_front();
          compare_field("status", 32'(oldest.status), 32'(rsp_i.data.status));
          compare_field("need_met", 32'(oldest.need_met), 32'(rsp_i.data.need_met));
          compare_field("left_0", 32'(oldest.left_0), 32'(rsp_i.data.left_0));
          compare_field("left_1", 32'(oldest.left_1), 32'(rsp_i.data.left_1));
          compare_field("left_2", 32'(oldest.left_2), 32'(rsp_i.data.left_2));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.addr)
          bsa_pkg::CFG_TOTAL_0: total_units[0] = cfg_i.data.wdata;
          bsa_pkg::CFG_TOTAL_1: total_units[1] = cfg_i.data.wdata;
          bsa_pkg::CFG_TOTAL_2: total_units[2] = cfg_i.data.wdata;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        pending_answers.push_back(predict_allocation(req_i.data));
      end
      pending_o    <= pending_answers.size();
      mismatches_o <= mismatch_total;
    end
  end

endmodule

@@ tb/sv/bankers_safe_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safe_allocator_test
// Drives the allocator with a directed opening, then phases of random restarts,
// claims, requests, releases and raw words under several unit totals, with
// bursty requests and a stalling result side; the checker judges every result.
// ----------------------------------------------------------------------------
module bankers_safe_allocator_test;

  localparam int unsigned CUSTOMERS = 8;
  localparam int unsigned LONG_HOLD = 400;

  logic           clk = 1'b0;
  logic           rst_n;
  int unsigned    mismatches;
  int unsigned    pending;
  int unsigned    hold_asks;
  int unsigned    holds_done;
  int unsigned    burst_left;
  bsa_pkg::unit_t cur_total   [bsa_pkg::RTYPES];
  bsa_pkg::unit_t claim_guess [CUSTOMERS][bsa_pkg::RTYPES];

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();
  bsa_cfg_if cfg_ch ();

  bankers_safe_allocator #(
    .CUSTOMERS(CUSTOMERS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  bankers_safe_allocator_checker #(
    .CUSTOMERS(CUSTOMERS)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .cfg_i       (cfg_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bsa_pkg::req_t make_op(input bsa_pkg::opcode_e opc,
                                            input int unsigned cust,
                                            input int unsigned a0, input int unsigned a1,
                                            input int unsigned a2);
    bsa_pkg::req_t op;
    op.opcode   = opc;
    op.customer = bsa_pkg::CUST_W'(cust);
    op.amount_0 = bsa_pkg::unit_t'(a0);
    op.amount_1 = bsa_pkg::unit_t'(a1);
    op.amount_2 = bsa_pkg::unit_t'(a2);
    return op;
  endfunction

  function automatic bsa_pkg::req_t random_op();
    bsa_pkg::req_t                    op;
    logic [$bits(bsa_pkg::req_t)-1:0] raw;
    int unsigned                      pick;
    int unsigned                      c;
    bsa_pkg::unit_t                   amt [bsa_pkg::RTYPES];
    pick = $urandom_range(0, 99);
    c    = $urandom_range(0, (1 << bsa_pkg::CUST_W) - 1);
    if (pick < 4) begin
      raw = $bits(bsa_pkg::req_t)'($urandom);
      op  = raw;
    end else if (pick < 7) begin
      op = make_op(bsa_pkg::OP_RESTART, c, 0, 0, 0);
      for (int k = 0; k < CUSTOMERS; k++) begin
        for (int r = 0; r < bsa_pkg::RTYPES; r++) claim_guess[k][r] = '0;
      end
    end else if (pick < 27) begin
      for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
        amt[r] = ($urandom_range(0, 9) == 0)
                 ? bsa_pkg::unit_t'($urandom_range(0, 255))
                 : bsa_pkg::unit_t'($urandom_range(0, cur_total[r]));
        if (c < CUSTOMERS) claim_guess[c][r] = amt[r];
      end
      op = make_op(bsa_pkg::OP_CLAIM, c, amt[0], amt[1], amt[2]);
    end else if (pick < 82) begin
      // mostly within the claim so that grants and safety checks happen
      for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
        if (c >= CUSTOMERS) begin
          amt[r] = bsa_pkg::unit_t'($urandom_range(0, 255));
        end else if ($urandom_range(0, 1)) begin
          amt[r] = bsa_pkg::unit_t'($urandom_range(0, claim_guess[c][r]));
        end else begin
          amt[r] = bsa_pkg::unit_t'($urandom_range(0, claim_guess[c][r] / 2));
        end
      end
      op = make_op(bsa_pkg::OP_REQUEST, c, amt[0], amt[1], amt[2]);
    end else begin
      op = make_op(bsa_pkg::OP_RELEASE, c, $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    end
    return op;
  endfunction

  // offer one request; bursts end with a random gap
  task automatic issue(input bsa_pkg::req_t op);
    int unsigned gap;
    req_ch.data  <= op;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bsa_pkg::CFG_W-1:0] addr,
                           input bsa_pkg::unit_t value);
    cfg_ch.data  <= '{addr: addr, wdata: value};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_totals(input bsa_pkg::unit_t t0, input bsa_pkg::unit_t t1,
                              input bsa_pkg::unit_t t2);
    write_reg(bsa_pkg::CFG_TOTAL_0, t0);
    write_reg(bsa_pkg::CFG_TOTAL_1, t1);
    write_reg(bsa_pkg::CFG_TOTAL_2, t2);
    cfg_ch.valid <= 1'b0;
    cur_total[0] = t0;
    cur_total[1] = t1;
    cur_total[2] = t2;
  endtask

  task automatic run_phase(input bsa_pkg::unit_t t0, input bsa_pkg::unit_t t1,
                           input bsa_pkg::unit_t t2, input bit fresh,
                           input int unsigned count, input bit squeeze);
    bsa_pkg::unit_t amt [bsa_pkg::RTYPES];
    write_totals(t0, t1, t2);
    if (fresh) begin
      issue(make_op(bsa_pkg::OP_RESTART, 0, 0, 0, 0));
      for (int k = 0; k < CUSTOMERS; k++) begin
        for (int r = 0; r < bsa_pkg::RTYPES; r++) claim_guess[k][r] = '0;
      end
    end
    for (int k = 0; k < CUSTOMERS; k++) begin
      for (int r = 0; r < bsa_pkg::RTYPES; r++) begin
        amt[r]            = bsa_pkg::unit_t'($urandom_range(0, cur_total[r]));
        claim_guess[k][r] = amt[r];
      end
      issue(make_op(bsa_pkg::OP_CLAIM, k, amt[0], amt[1], amt[2]));
    end
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 3) hold_asks++;
      issue(random_op());
    end
    drain();
  endtask

  // result side: a long hold when asked, otherwise a changing stall pattern
  initial begin
    int unsigned stall_left;
    int unsigned mode;
    int unsigned mode_left;
    stall_left = 0;
    mode       = 0;
    mode_left  = 0;
    holds_done = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_asks != holds_done) begin
        holds_done++;
        stall_left = LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;
    hold_asks  = 0;
    burst_left = 0;
    for (int r = 0; r < bsa_pkg::RTYPES; r++) cur_total[r] = '0;
    for (int k = 0; k < CUSTOMERS; k++) begin
      for (int r = 0; r < bsa_pkg::RTYPES; r++) claim_guess[k][r] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: every status, need met, rollback, claim below holding
    write_totals(8'd255, 8'd10, 8'd255);
    issue(make_op(bsa_pkg::OP_RESTART, 0, 0, 0, 0));
    issue(make_op(bsa_pkg::OP_CLAIM, 0, 255, 10, 255));
    issue(make_op(bsa_pkg::OP_CLAIM, 7, 255, 10, 0));
    issue(make_op(bsa_pkg::OP_CLAIM, 1, 0, 11, 0));
    issue(make_op(bsa_pkg::OP_REQUEST, 0, 200, 0, 0));
    issue(make_op(bsa_pkg::OP_REQUEST, 7, 55, 5, 0));
    issue(make_op(bsa_pkg::OP_REQUEST, 7, 56, 0, 0));
    issue(make_op(bsa_pkg::OP_REQUEST, 7, 0, 0, 1));
    issue(make_op(bsa_pkg::OP_CLAIM, 0, 100, 10, 255));
    issue(make_op(bsa_pkg::OP_REQUEST, 0, 55, 10, 255));
    issue(make_op(bsa_pkg::OP_REQUEST, 7, 0, 0, 0));
    issue(make_op(bsa_pkg::OP_RELEASE, 0, 255, 255, 255));
    issue(make_op(bsa_pkg::OP_REQUEST, 3, 0, 0, 0));
    issue(make_op(bsa_pkg::OP_RELEASE, 5, 0, 0, 0));
    issue(make_op(bsa_pkg::OP_CLAIM, 0, 0, 0, 0));
    issue(make_op(bsa_pkg::OP_REQUEST, 7, 255, 10, 0));
    issue(make_op(bsa_pkg::OP_CLAIM, 7, 254, 10, 0));
    issue(make_op(bsa_pkg::OP_RELEASE, 7, 0, 0, 0));
    issue(make_op(bsa_pkg::OP_REQUEST, 2, 255, 255, 255));
    issue(make_op(bsa_pkg::OP_RESTART, 6, 255, 255, 255));
    drain();

    run_phase(8'd255, 8'd255, 8'd255, 1'b1, 180, 1'b0);
    run_phase(8'd0, 8'd0, 8'd0, 1'b1, 50, 1'b0);
    run_phase(8'd7, 8'd3, 8'd12, 1'b1, 280, 1'b1);
    run_phase(bsa_pkg::unit_t'($urandom_range(1, 20)),
              bsa_pkg::unit_t'($urandom_range(1, 20)),
              bsa_pkg::unit_t'($urandom_range(1, 20)), 1'b1, 280, 1'b0);
    // totals change under a live state: claims see the new limits
    run_phase(8'd1, 8'd255, 8'd0, 1'b0, 130, 1'b0);
    run_phase(bsa_pkg::unit_t'($urandom_range(0, 255)),
              bsa_pkg::unit_t'($urandom_range(0, 255)),
              bsa_pkg::unit_t'($urandom_range(0, 255)), 1'b1, 180, 1'b0);
    run_phase(bsa_pkg::unit_t'($urandom_range(2, 10)),
              bsa_pkg::unit_t'($urandom_range(2, 10)),
              bsa_pkg::unit_t'($urandom_range(2, 10)), 1'b1, 200, 1'b1);

    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_intf.sv
rtl/bsa_store.sv
rtl/bsa_lane_alu.sv
rtl/bankers_safe_allocator.sv
rtl/bsa_checker.sv
tb/sv/bankers_safe_allocator_checker.sv
tb/sv/bankers_safe_allocator_test.sv
